/* rtl/core/rip_pkg.sv */
package rip_pkg;

   // input word modes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam int AREA_BITS = 41;

   // per-edge operation sequence: 16 issued ops, then the pipeline drains
   localparam int         OP_BITS  = 5;
   localparam logic [4:0] OP_COUNT = 5'd16;
   localparam logic [4:0] OP_LAST  = 5'd17;

   // operation groups, upper two bits of the op code
   localparam logic [1:0] OPG_SIDE  = 2'd0;
   localparam logic [1:0] OPG_RAY   = 2'd1;
   localparam logic [1:0] OPG_RECT0 = 2'd2;
   localparam logic [1:0] OPG_RECT1 = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [3:0] op;
   } op_tag_type;

endpackage

/* rtl/core/rip_if.sv */
interface rip_req_if #(parameter int COORD_BITS = 20);
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [COORD_BITS-1:0] first_x;
   logic [COORD_BITS-1:0] first_y;
   logic [COORD_BITS-1:0] second_x;
   logic [COORD_BITS-1:0] second_y;

   modport source (output valid, mode, first_x, first_y, second_x, second_y, input ready);
   modport sink (input valid, mode, first_x, first_y, second_x, second_y, output ready);
endinterface

interface rip_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           contained;
   logic [rip_pkg::AREA_BITS-1:0]  area;

   modport source (output valid, contained, area, input ready);
   modport sink (input valid, contained, area, output ready);
endinterface

/* rtl/core/rip_ram.sv */
module rip_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rip_mul_unit.sv */
// two products and their difference, p*q - r*s, two stage pipeline
module rip_mul_unit #(
   parameter int DW = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rip_pkg::op_tag_type      tag_in,
   input  logic signed [DW-1:0]     op_p,
   input  logic signed [DW-1:0]     op_q,
   input  logic signed [DW-1:0]     op_r,
   input  logic signed [DW-1:0]     op_s,
   output rip_pkg::op_tag_type      tag_out,
   output logic signed [2*DW:0]     diff
);

   logic signed [2*DW-1:0] pq_ff, pq_in;
   logic signed [2*DW-1:0] rs_ff, rs_in;
   logic signed [2*DW:0]   diff_ff, diff_in;
   rip_pkg::op_tag_type    tag1_ff, tag2_ff;

   always_comb begin
      pq_in   = op_p * op_q;
      rs_in   = op_r * op_s;
      diff_in = {pq_ff[2*DW-1], pq_ff} - {rs_ff[2*DW-1], rs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
      pq_ff   <= pq_in;
      rs_ff   <= rs_in;
      diff_ff <= diff_in;
   end

   assign tag_out = tag2_ff;
   assign diff    = diff_ff;

endmodule

/* rtl/core/rect_in_polygon_test_core.sv */
// Rectangle-in-polygon test. Mode 0 words clear the polygon, mode 1 words append a vertex
// (ignored once MAX_VERTICES are stored), mode 2 words query an axis-aligned rectangle
// given by two opposite corners and return one word: contained, set when all four corners
// are inside the closed polygon (vertex and edge hits count as inside, ray casting
// otherwise) and no polygon edge properly crosses a rectangle edge, plus the inclusive
// area. Mode 3 words are dropped. Clear and append complete without leaving the idle state.
// A query walks the vertices, which sit in one single-port-read memory, once, one edge at
// a time; each edge costs a vertex load (none for the closing edge, whose far end is kept
// in a register), sixteen operations issued back to back into a shared two-multiplier
// unit (four corner side tests, four ray tests done as exact cross-multiplied compares,
// eight rectangle side tests), pipeline drain and an evaluation step. One item is worked
// on at a time; the result sits in an output register so the next item is taken while
// it waits.
module rect_in_polygon_test_core #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 20
) (
   input  logic        clock,
   input  logic        reset,
   rip_req_if.sink     req_chan,
   rip_rsp_if.source   rsp_chan
);

   localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W    = $clog2(MAX_VERTICES);
   localparam int DW        = COORD_BITS + 2;
   localparam int PROD_W    = 2 * (COORD_BITS + 1);
   localparam int AREA_FULL = (PROD_W > rip_pkg::AREA_BITS) ? PROD_W : rip_pkg::AREA_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_AREA, S_FIRST, S_LOAD, S_EDGE, S_EVAL, S_DONE
   } state_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   function automatic logic signed [DW-1:0] ext(input coord_type v);
      return $signed({2'b00, v});
   endfunction

   state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [rip_pkg::OP_BITS-1:0] op_ff, op_in;

   // rectangle, polygon edge endpoints a/b, first vertex
   coord_type lx_ff, lx_in, ly_ff, ly_in, hx_ff, hx_in, hy_ff, hy_in;
   coord_type ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   coord_type fx_ff, fx_in, fy_ff, fy_in;
   logic [rip_pkg::AREA_BITS-1:0] area_ff, area_in;
   logic res_ff, res_in;

   // per-corner accumulators and per-edge side signs
   logic [3:0] on_ff, on_in, par_ff, par_in;
   logic       cross_ff, cross_in;
   logic [3:0] sp_ff, sp_in, sn_ff, sn_in;
   logic [7:0] rp_ff, rp_in, rn_ff, rn_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_contained_ff, rsp_contained_in;
   logic [rip_pkg::AREA_BITS-1:0] rsp_area_ff, rsp_area_in;

   // memory ports
   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [2*COORD_BITS-1:0] wr_data, rd_data;

   // shared multiplier unit
   rip_pkg::op_tag_type  tag_issue, tag_done;
   logic signed [DW-1:0] op_p, op_q, op_r, op_s;
   logic signed [2*DW:0] diff;

   // rectangle corners in edge order: (lo,lo) (hi,lo) (hi,hi) (lo,hi)
   coord_type cx [4];
   coord_type cy [4];

   logic [CNT_W:0] k_next1, k_next2, count_ext;
   logic [COORD_BITS:0] width_w, height_w;
   logic [AREA_FULL-1:0] area_full;

   rip_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_VERTICES)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rip_mul_unit #(.DW(DW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_issue),
      .op_p    (op_p),
      .op_q    (op_q),
      .op_r    (op_r),
      .op_s    (op_s),
      .tag_out (tag_done),
      .diff    (diff)
   );

   assign cx[0] = lx_ff; assign cy[0] = ly_ff;
   assign cx[1] = hx_ff; assign cy[1] = ly_ff;
   assign cx[2] = hx_ff; assign cy[2] = hy_ff;
   assign cx[3] = lx_ff; assign cy[3] = hy_ff;

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.contained = rsp_contained_ff;
   assign rsp_chan.area      = rsp_area_ff;

   assign k_next1   = {1'b0, k_ff} + (CNT_W + 1)'(1);
   assign k_next2   = {1'b0, k_ff} + (CNT_W + 1)'(2);
   assign count_ext = {1'b0, count_ff};

   // inclusive area from the registered corners
   assign width_w   = {1'b0, hx_ff} - {1'b0, lx_ff} + (COORD_BITS + 1)'(1);
   assign height_w  = {1'b0, hy_ff} - {1'b0, ly_ff} + (COORD_BITS + 1)'(1);
   assign area_full = AREA_FULL'(width_w) * AREA_FULL'(height_w);

   // operand selection for the op being issued
   always_comb begin
      logic [1:0] sel;
      logic [1:0] r0, r1;
      logic signed [DW-1:0] t;
      coord_type px, py;
      sel = op_ff[1:0];
      r0  = op_ff[2:1];
      r1  = op_ff[2:1] + 2'd1;
      t   = ext(cx[sel]) - ext(bx_ff);
      px  = op_ff[0] ? bx_ff : ax_ff;
      py  = op_ff[0] ? by_ff : ay_ff;
      tag_issue.valid = (state_ff == S_EDGE) && (op_ff < rip_pkg::OP_COUNT);
      tag_issue.op    = op_ff[3:0];
      unique case (op_ff[3:2])
         rip_pkg::OPG_SIDE: begin
            // side of corner against polygon edge, also the on-segment cross product
            op_p = ext(bx_ff) - ext(ax_ff);
            op_q = ext(cy[sel]) - ext(ay_ff);
            op_r = ext(by_ff) - ext(ay_ff);
            op_s = ext(cx[sel]) - ext(ax_ff);
         end
         rip_pkg::OPG_RAY: begin
            // N - t'*D with N = (ax-bx)(ty-by), D = ay-by, t' = t+1 for t >= 0
            op_p = ext(ax_ff) - ext(bx_ff);
            op_q = ext(cy[sel]) - ext(by_ff);
            op_r = t[DW-1] ? t : t + DW'(1);
            op_s = ext(ay_ff) - ext(by_ff);
         end
         default: begin
            // side of a polygon endpoint against rectangle edge
            op_p = ext(cx[r1]) - ext(cx[r0]);
            op_q = ext(py) - ext(cy[r0]);
            op_r = ext(cy[r1]) - ext(cy[r0]);
            op_s = ext(px) - ext(cx[r0]);
         end
      endcase
   end

   always_comb begin
      logic [1:0] k;
      logic zero, neg, pos;
      logic straddle, dpos, tneg, flip, in_box;
      logic [3:0] corner_in;
      coord_type lox, hix, loy, hiy;
      logic opp12, opp34;

      state_in         = state_ff;
      count_in         = count_ff;
      k_in             = k_ff;
      op_in            = op_ff;
      lx_in = lx_ff; ly_in = ly_ff; hx_in = hx_ff; hy_in = hy_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      fx_in = fx_ff; fy_in = fy_ff;
      area_in          = area_ff;
      res_in           = res_ff;
      on_in            = on_ff;
      par_in           = par_ff;
      cross_in         = cross_ff;
      sp_in            = sp_ff;
      sn_in            = sn_ff;
      rp_in            = rp_ff;
      rn_in            = rn_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_contained_in = rsp_contained_ff;
      rsp_area_in      = rsp_area_ff;
      wr_en            = 1'b0;
      wr_addr          = count_ff[ADDR_W-1:0];
      wr_data          = {req_chan.first_y, req_chan.first_x};
      rd_en            = 1'b0;
      rd_addr          = '0;

      // result of the op leaving the multiplier unit
      k        = tag_done.op[1:0];
      zero     = (diff == '0);
      neg      = diff[2*DW];
      pos      = !neg && !zero;
      lox      = (ax_ff < bx_ff) ? ax_ff : bx_ff;
      hix      = (ax_ff < bx_ff) ? bx_ff : ax_ff;
      loy      = (ay_ff < by_ff) ? ay_ff : by_ff;
      hiy      = (ay_ff < by_ff) ? by_ff : ay_ff;
      in_box   = (cx[k] >= lox) && (cx[k] <= hix) && (cy[k] >= loy) && (cy[k] <= hiy);
      straddle = (by_ff > cy[k]) != (ay_ff > cy[k]);
      dpos     = ay_ff > by_ff;
      tneg     = cx[k] < bx_ff;
      if (dpos) begin
         flip = tneg ? pos : !neg;
      end else begin
         flip = tneg ? neg : (neg || zero);
      end
      if (tag_done.valid) begin
         unique case (tag_done.op[3:2])
            rip_pkg::OPG_SIDE: begin
               sp_in[k] = pos;
               sn_in[k] = neg;
               if (zero && in_box) begin
                  on_in[k] = 1'b1;
               end
            end
            rip_pkg::OPG_RAY: begin
               if (straddle && flip) begin
                  par_in[k] = !par_ff[k];
               end
            end
            default: begin
               rp_in[tag_done.op[2:0]] = pos;
               rn_in[tag_done.op[2:0]] = neg;
            end
         endcase
      end

      corner_in = on_ff | par_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               unique case (req_chan.mode)
                  rip_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  rip_pkg::MODE_APPEND: begin
                     if (count_ff < CNT_W'(MAX_VERTICES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  rip_pkg::MODE_QUERY: begin
                     lx_in    = (req_chan.first_x < req_chan.second_x) ?
                                req_chan.first_x : req_chan.second_x;
                     hx_in    = (req_chan.first_x < req_chan.second_x) ?
                                req_chan.second_x : req_chan.first_x;
                     ly_in    = (req_chan.first_y < req_chan.second_y) ?
                                req_chan.first_y : req_chan.second_y;
                     hy_in    = (req_chan.first_y < req_chan.second_y) ?
                                req_chan.second_y : req_chan.first_y;
                     state_in = S_AREA;
                  end
                  default: begin
                     // mode three: dropped
                  end
               endcase
            end
         end
         S_AREA: begin
            area_in  = area_full[rip_pkg::AREA_BITS-1:0];
            on_in    = '0;
            par_in   = '0;
            cross_in = 1'b0;
            k_in     = '0;
            if (count_ff == '0) begin
               // empty polygon: nothing is inside
               res_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            fx_in = rd_data[COORD_BITS-1:0];
            fy_in = rd_data[2*COORD_BITS-1:COORD_BITS];
            ax_in = rd_data[COORD_BITS-1:0];
            ay_in = rd_data[2*COORD_BITS-1:COORD_BITS];
            op_in = '0;
            if (count_ff == CNT_W'(1)) begin
               // single vertex: the one edge folds back on itself
               bx_in    = rd_data[COORD_BITS-1:0];
               by_in    = rd_data[2*COORD_BITS-1:COORD_BITS];
               state_in = S_EDGE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(1);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            bx_in    = rd_data[COORD_BITS-1:0];
            by_in    = rd_data[2*COORD_BITS-1:COORD_BITS];
            op_in    = '0;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            op_in = op_ff + rip_pkg::OP_BITS'(1);
            if (op_ff == rip_pkg::OP_LAST) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            for (int r = 0; r < 4; r++) begin
               opp12 = (rp_ff[2*r] && rn_ff[2*r+1]) || (rn_ff[2*r] && rp_ff[2*r+1]);
               opp34 = (sp_ff[r] && sn_ff[(r+1)%4]) || (sn_ff[r] && sp_ff[(r+1)%4]);
               if (opp12 && opp34) begin
                  cross_in = 1'b1;
               end
            end
            if (k_next1 == count_ext) begin
               res_in   = (&corner_in) && !cross_in;
               state_in = S_DONE;
            end else begin
               ax_in = bx_ff;
               ay_in = by_ff;
               k_in  = k_next1[CNT_W-1:0];
               op_in = '0;
               if (k_next2 == count_ext) begin
                  // closing edge back to the first vertex
                  bx_in    = fx_ff;
                  by_in    = fy_ff;
                  state_in = S_EDGE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = k_next2[ADDR_W-1:0];
                  state_in = S_LOAD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_contained_in = res_ff;
               rsp_area_in      = area_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff             <= k_in;
      op_ff            <= op_in;
      lx_ff            <= lx_in;
      ly_ff            <= ly_in;
      hx_ff            <= hx_in;
      hy_ff            <= hy_in;
      ax_ff            <= ax_in;
      ay_ff            <= ay_in;
      bx_ff            <= bx_in;
      by_ff            <= by_in;
      fx_ff            <= fx_in;
      fy_ff            <= fy_in;
      area_ff          <= area_in;
      res_ff           <= res_in;
      on_ff            <= on_in;
      par_ff           <= par_in;
      cross_ff         <= cross_in;
      sp_ff            <= sp_in;
      sn_ff            <= sn_in;
      rp_ff            <= rp_in;
      rn_ff            <= rn_in;
      rsp_contained_ff <= rsp_contained_in;
      rsp_area_ff      <= rsp_area_in;
   end

endmodule
